[src/cpst_pkg.sv]
// Shared types and constants for the process scheduler tick block.
package cpst_pkg;

  localparam int unsigned PROCESS_SLOTS_DEFAULT = 16;
  localparam int unsigned ARRIVAL_LIMIT_DEFAULT = 1000;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_TICK    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;
  localparam logic [1:0] FUNC_NOP     = 2'd3;

  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_PRIO = 2'd2;
  localparam logic [1:0] POL_RR   = 2'd3;

  localparam logic [1:0] CFG_POLICY  = 2'd0;
  localparam logic [1:0] CFG_PREEMPT = 2'd1;
  localparam logic [1:0] CFG_QUANTUM = 2'd2;

  localparam logic [1:0] LOAD_OK   = 2'd0;
  localparam logic [1:0] LOAD_DUP  = 2'd1;
  localparam logic [1:0] LOAD_DROP = 2'd2;

  localparam logic [1:0] EV_RUN  = 2'd0;
  localparam logic [1:0] EV_DONE = 2'd1;
  localparam logic [1:0] EV_IO   = 2'd2;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_SCAN,
    ST_LOAD_SHIFT,
    ST_RESTART,
    ST_ARRIVE,
    ST_PICK,
    ST_DECIDE,
    ST_AGE_READY,
    ST_AGE_IO,
    ST_RUN,
    ST_REPORT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_scan;
    logic load_shift;
    logic load_write;
    logic restart_step;
    logic arrive_step;
    logic pick_step;
    logic decide;
    logic age_ready_step;
    logic age_io_step;
    logic run;
    logic report;
    logic clear_index;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_bad;
    logic index_last;
    logic shift_done;
    logic io_last;
  } status_t;

endpackage

[src/cpst_ctrl.sv]
// Controller state machine for the process scheduler tick block.
module cpst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         func,
  input  cpst_pkg::status_t  status,
  output logic               busy,
  output cpst_pkg::cmd_t     cmd
);
  import cpst_pkg::*;

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          cmd.clear_index = 1'b1;
          case (func)
            FUNC_LOAD:    state_next = ST_LOAD_SCAN;
            FUNC_TICK:    state_next = ST_ARRIVE;
            FUNC_RESTART: state_next = ST_RESTART;
            default:      state_next = ST_REPORT;
          endcase
        end
      end
      ST_LOAD_SCAN: begin
        if (status.load_bad) begin
          state_next = ST_REPORT;
        end else begin
          cmd.load_scan = 1'b1;
          if (status.index_last) begin
            state_next = ST_LOAD_SHIFT;
          end
        end
      end
      ST_LOAD_SHIFT: begin
        if (status.shift_done) begin
          cmd.load_write = 1'b1;
          cmd.clear_index = 1'b1;
          state_next = ST_RESTART;
        end else begin
          cmd.load_shift = 1'b1;
        end
      end
      ST_RESTART: begin
        cmd.restart_step = 1'b1;
        if (status.index_last) begin
          state_next = ST_REPORT;
        end
      end
      ST_ARRIVE: begin
        cmd.arrive_step = 1'b1;
        if (status.index_last) begin
          cmd.clear_index = 1'b1;
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        cmd.pick_step = 1'b1;
        if (status.index_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.clear_index = 1'b1;
        state_next = ST_AGE_READY;
      end
      ST_AGE_READY: begin
        cmd.age_ready_step = 1'b1;
        if (status.index_last) begin
          cmd.clear_index = 1'b1;
          state_next = ST_AGE_IO;
        end
      end
      ST_AGE_IO: begin
        cmd.age_io_step = 1'b1;
        if (status.io_last) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.run = 1'b1;
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        cmd.report = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/cpst_datapath.sv]
// Process table, queues and counters of the process scheduler tick block.
module cpst_datapath #(
  parameter int unsigned PROCESS_SLOTS = cpst_pkg::PROCESS_SLOTS_DEFAULT,
  parameter int unsigned ARRIVAL_LIMIT = cpst_pkg::ARRIVAL_LIMIT_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  cpst_pkg::cmd_t     cmd,
  output cpst_pkg::status_t  status,
  input  logic [1:0]         func,
  input  logic [15:0]        proc_id,
  input  logic [7:0]         prio_level,
  input  logic [9:0]         arrival_tick,
  input  logic [9:0]         cpu_need,
  input  logic [9:0]         io_need,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               done,
  output logic [1:0]         load_status,
  output logic [15:0]        tick_now,
  output logic               cpu_busy,
  output logic [15:0]        run_id,
  output logic [1:0]         run_event,
  output logic               was_preempted,
  output logic [6:0]         io_finished,
  output logic [15:0]        wait_total,
  output logic [15:0]        turnaround_total,
  output logic [15:0]        response_delay,
  output logic               all_finished
);
  import cpst_pkg::*;

  localparam int unsigned SW = $clog2(PROCESS_SLOTS);
  localparam int unsigned CW = $clog2(PROCESS_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS = CW'(PROCESS_SLOTS);

  // Configuration registers.
  logic [1:0] policy;
  logic       allow_preempt;
  logic [7:0] quantum;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_FCFS;
      allow_preempt <= 1'b0;
      quantum <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY:  policy <= cfg_data[1:0];
        CFG_PREEMPT: allow_preempt <= cfg_data[0];
        CFG_QUANTUM: quantum <= cfg_data;
        default: ;
      endcase
    end
  end

  // Process table; every slot is a register read at a scan index.
  logic [15:0] e_pid   [PROCESS_SLOTS];
  logic [7:0]  e_prio  [PROCESS_SLOTS];
  logic [9:0]  e_arr   [PROCESS_SLOTS];
  logic [9:0]  e_cpu_o [PROCESS_SLOTS];
  logic [9:0]  e_io_o  [PROCESS_SLOTS];
  logic [9:0]  e_cpu   [PROCESS_SLOTS];
  logic [9:0]  e_io    [PROCESS_SLOTS];
  logic [15:0] e_wait  [PROCESS_SLOTS];
  logic [15:0] e_turn  [PROCESS_SLOTS];
  logic [16:0] e_resp  [PROCESS_SLOTS];
  logic [PROCESS_SLOTS-1:0] e_na;
  logic [SW-1:0] rq [PROCESS_SLOTS];
  logic [SW-1:0] iq [PROCESS_SLOTS];

  logic [CW-1:0] ready_count, io_count, loaded_count, done_count;
  logic [SW-1:0] running_slot;
  logic          running_valid;
  logic [7:0]    slice_used;
  logic [15:0]   tick_count;

  // Captured input beat.
  logic [1:0]  in_func;
  logic [15:0] in_pid;
  logic [7:0]  in_prio;
  logic [9:0]  in_arr, in_cpu, in_io;

  // Scan state.
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic          dup;
  logic          stored;
  logic [SW-1:0] take;
  logic [CW-1:0] shift_i;
  logic          prev_valid;
  logic [SW-1:0] prev_slot;
  logic          preempted;
  logic [6:0]    finished;

  logic [SW-1:0] idx_s;
  assign idx_s = idx[SW-1:0];

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Key for the shortest job or priority policy.
  function automatic logic [9:0] key_of(input logic [1:0] pol, input logic [9:0] cpu,
                                        input logic [7:0] pr);
    return (pol == POL_SJF) ? cpu : {2'b00, pr};
  endfunction

  logic [9:0] ka, kb, kr;
  logic [SW-1:0] cand, best;
  logic beats, rbeat;
  logic scan_end, io_end;
  logic load_bad;

  always_comb begin
    cand = rq[idx_s];
    best = rq[take];
    ka = key_of(policy, e_cpu[cand], e_prio[cand]);
    kb = key_of(policy, e_cpu[best], e_prio[best]);
    kr = key_of(policy, e_cpu[running_slot], e_prio[running_slot]);
    beats = (ka < kb) || ((ka == kb) && (e_arr[cand] < e_arr[best]));
    rbeat = (kr > kb) || ((kr == kb) && (e_arr[running_slot] > e_arr[best]));
    load_bad = ({6'd0, in_arr} > 16'(ARRIVAL_LIMIT)) || (in_cpu == 10'd0) ||
               (loaded_count >= SLOTS);
  end

  // Scan end flags depend on the phase the controller is in.
  always_comb begin
    scan_end = 1'b1;
    if (cmd.load_scan || cmd.restart_step || cmd.arrive_step) begin
      scan_end = (idx + CW'(1) >= loaded_count);
    end else if (cmd.pick_step || cmd.age_ready_step) begin
      scan_end = (idx + CW'(1) >= ready_count);
    end
    io_end = (idx >= io_count);
    status.load_bad = load_bad;
    status.index_last = scan_end;
    status.shift_done = (shift_i <= pos);
    status.io_last = io_end;
  end

  logic [SW-1:0] io_s;
  logic [9:0]    io_left_next;
  logic [9:0]    cpu_left_next;
  logic [SW-1:0] rs;
  logic          idx_inc;
  logic          run_done;
  assign io_s = iq[idx_s];
  assign io_left_next = (e_io[io_s] > 10'd0) ? e_io[io_s] - 10'd1 : 10'd0;
  assign rs = running_slot;
  assign cpu_left_next = (e_cpu[rs] > 10'd0) ? e_cpu[rs] - 10'd1 : 10'd0;
  assign run_done = running_valid && (cpu_left_next == 10'd0);

  // The scan index steps in every scan phase; an IO entry that leaves holds it.
  assign idx_inc = cmd.load_scan || cmd.restart_step || cmd.arrive_step ||
                   cmd.pick_step || cmd.age_ready_step ||
                   (cmd.age_io_step && !io_end && (io_left_next != 10'd0));

  // Main sequential datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      e_na <= '0;
      ready_count <= '0;
      io_count <= '0;
      loaded_count <= '0;
      done_count <= '0;
      running_slot <= '0;
      running_valid <= 1'b0;
      slice_used <= '0;
      tick_count <= '0;
      done <= 1'b0;
      idx <= '0;
    end else begin
      done <= cmd.report;
      if (cmd.capture) begin
        in_func <= func;
        in_pid <= proc_id;
        in_prio <= prio_level;
        in_arr <= arrival_tick;
        in_cpu <= cpu_need;
        in_io <= io_need;
        pos <= '0;
        dup <= 1'b0;
        stored <= 1'b0;
        take <= '0;
        preempted <= 1'b0;
        finished <= '0;
        prev_valid <= running_valid;
        prev_slot <= running_slot;
        shift_i <= loaded_count;
      end

      // Scan index.
      if (cmd.clear_index) begin
        idx <= '0;
      end else if (idx_inc) begin
        idx <= idx + CW'(1);
      end

      // Load: find the place and duplicate, then shift entries up by one.
      if (cmd.load_scan) begin
        if (idx < loaded_count) begin
          if (e_pid[idx_s] == in_pid) dup <= 1'b1;
          if (e_pid[idx_s] <= in_pid) pos <= idx + CW'(1);
        end
      end
      if (cmd.load_shift) begin
        e_pid[shift_i[SW-1:0]]   <= e_pid[SW'(shift_i - CW'(1))];
        e_prio[shift_i[SW-1:0]]  <= e_prio[SW'(shift_i - CW'(1))];
        e_arr[shift_i[SW-1:0]]   <= e_arr[SW'(shift_i - CW'(1))];
        e_cpu_o[shift_i[SW-1:0]] <= e_cpu_o[SW'(shift_i - CW'(1))];
        e_io_o[shift_i[SW-1:0]]  <= e_io_o[SW'(shift_i - CW'(1))];
        shift_i <= shift_i - CW'(1);
      end
      if (cmd.load_write) begin
        e_pid[pos[SW-1:0]]   <= in_pid;
        e_prio[pos[SW-1:0]]  <= in_prio;
        e_arr[pos[SW-1:0]]   <= in_arr;
        e_cpu_o[pos[SW-1:0]] <= in_cpu;
        e_io_o[pos[SW-1:0]]  <= in_io;
        loaded_count <= loaded_count + CW'(1);
        stored <= 1'b1;
      end

      // Restart: one slot per cycle, and clear run state.
      if (cmd.restart_step) begin
        if (idx < loaded_count || cmd.load_write) begin
          e_cpu[idx_s] <= e_cpu_o[idx_s];
          e_io[idx_s] <= e_io_o[idx_s];
          e_wait[idx_s] <= '0;
          e_turn[idx_s] <= '0;
          e_resp[idx_s] <= 17'h10000;
          e_na[idx_s] <= 1'b1;
        end
        ready_count <= '0;
        io_count <= '0;
        done_count <= '0;
        running_slot <= '0;
        running_valid <= 1'b0;
        slice_used <= '0;
        tick_count <= '0;
      end

      // Arrivals: push matching slots in table order.
      if (cmd.arrive_step) begin
        if (idx < loaded_count && e_na[idx_s] && ({6'd0, e_arr[idx_s]} == tick_count)) begin
          e_na[idx_s] <= 1'b0;
          if (ready_count < SLOTS) begin
            rq[ready_count[SW-1:0]] <= idx_s;
            ready_count <= ready_count + CW'(1);
          end
        end
      end

      // Best candidate search over the ready queue.
      if (cmd.pick_step) begin
        if ((policy == POL_SJF || policy == POL_PRIO) && idx != '0 &&
            idx < ready_count && beats) begin
          take <= idx_s;
        end
      end

      // Swap decision, queue removal and response time.
      if (cmd.decide) begin
        logic swap;
        logic [SW-1:0] ns;
        swap = 1'b0;
        ns = running_slot;
        if (ready_count > '0) begin
          if (!running_valid) swap = 1'b1;
          else if (policy == POL_RR) swap = (slice_used >= quantum);
          else if (policy != POL_FCFS && allow_preempt) swap = rbeat;
        end
        if (swap) begin
          ns = rq[take];
          for (int i = 0; i < PROCESS_SLOTS - 1; i++) begin
            if (SW'(i) >= take && CW'(i + 1) < ready_count) rq[i] <= rq[i + 1];
          end
          if (running_valid) begin
            rq[SW'(ready_count - CW'(1))] <= running_slot;
            preempted <= 1'b1;
          end else begin
            ready_count <= ready_count - CW'(1);
          end
          running_slot <= ns;
          running_valid <= 1'b1;
        end
        if ((swap || running_valid) && (!prev_valid || prev_slot != ns)) begin
          slice_used <= '0;
          if (e_resp[ns][16]) e_resp[ns] <= {1'b0, tick_count - {6'd0, e_arr[ns]}};
        end
      end

      // Age ready entries.
      if (cmd.age_ready_step) begin
        if (idx < ready_count) begin
          e_wait[rq[idx_s]] <= sat16(e_wait[rq[idx_s]]);
          e_turn[rq[idx_s]] <= sat16(e_turn[rq[idx_s]]);
        end
      end

      // Age IO entries; a finished burst moves to the ready queue.
      if (cmd.age_io_step && !io_end) begin
        e_turn[io_s] <= sat16(e_turn[io_s]);
        e_io[io_s] <= io_left_next;
        if (io_left_next == 10'd0) begin
          for (int i = 0; i < PROCESS_SLOTS - 1; i++) begin
            if (SW'(i) >= idx_s && CW'(i + 1) < io_count) iq[i] <= iq[i + 1];
          end
          io_count <= io_count - CW'(1);
          if (ready_count < SLOTS) begin
            rq[ready_count[SW-1:0]] <= io_s;
            ready_count <= ready_count + CW'(1);
          end
          finished <= finished + 7'd1;
        end
      end

      // One CPU tick and the result beat.
      if (cmd.run) begin
        load_status <= LOAD_OK;
        tick_now <= tick_count;
        was_preempted <= preempted;
        io_finished <= finished;
        cpu_busy <= running_valid;
        run_id <= running_valid ? e_pid[rs] : 16'd0;
        if (run_done) begin
          run_event <= EV_DONE;
          wait_total <= e_wait[rs];
          turnaround_total <= sat16(e_turn[rs]);
          response_delay <= e_resp[rs][15:0];
        end else begin
          run_event <= (running_valid && e_io[rs] > 10'd0) ? EV_IO : EV_RUN;
          wait_total <= '0;
          turnaround_total <= '0;
          response_delay <= '0;
        end
        if (run_done && done_count < SLOTS) begin
          all_finished <= (done_count + CW'(1) == loaded_count);
        end else begin
          all_finished <= (done_count == loaded_count);
        end
        if (running_valid) begin
          e_cpu[rs] <= cpu_left_next;
          e_turn[rs] <= sat16(e_turn[rs]);
          if (slice_used != 8'hFF) slice_used <= slice_used + 8'd1;
          if (cpu_left_next == 10'd0) begin
            running_valid <= 1'b0;
            if (done_count < SLOTS) begin
              done_count <= done_count + CW'(1);
            end
          end else if (e_io[rs] > 10'd0) begin
            running_valid <= 1'b0;
            if (io_count < SLOTS) begin
              iq[io_count[SW-1:0]] <= rs;
              io_count <= io_count + CW'(1);
            end
          end
        end
        tick_count <= sat16(tick_count);
      end

      // Results of load, restart and unused codes.
      if (cmd.report && in_func != FUNC_TICK) begin
        tick_now <= '0;
        cpu_busy <= 1'b0;
        run_id <= '0;
        run_event <= EV_RUN;
        was_preempted <= 1'b0;
        io_finished <= '0;
        wait_total <= '0;
        turnaround_total <= '0;
        response_delay <= '0;
        all_finished <= 1'b0;
        if (in_func == FUNC_LOAD) begin
          load_status <= !stored ? LOAD_DROP : (dup ? LOAD_DUP : LOAD_OK);
        end else begin
          load_status <= LOAD_OK;
        end
      end
    end
  end

endmodule

[src/cpu_process_scheduler_tick.sv]
// Process scheduler tick block: a load, tick or restart command per beat.
// A tick scans the table, the ready queue and the IO queue; a load scans the table, shifts
// entries up and then rewinds every slot as a restart does.
// One command is in flight at a time; busy is high until its result strobe.
// Synchronous reset empties the table and restores the default configuration.
// Results carry a one-cycle done strobe and cannot be stalled.
module cpu_process_scheduler_tick #(
  parameter int unsigned PROCESS_SLOTS = cpst_pkg::PROCESS_SLOTS_DEFAULT,
  parameter int unsigned ARRIVAL_LIMIT = cpst_pkg::ARRIVAL_LIMIT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [15:0] proc_id,
  input  logic [7:0]  prio_level,
  input  logic [9:0]  arrival_tick,
  input  logic [9:0]  cpu_need,
  input  logic [9:0]  io_need,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [1:0]  load_status,
  output logic [15:0] tick_now,
  output logic        cpu_busy,
  output logic [15:0] run_id,
  output logic [1:0]  run_event,
  output logic        was_preempted,
  output logic [6:0]  io_finished,
  output logic [15:0] wait_total,
  output logic [15:0] turnaround_total,
  output logic [15:0] response_delay,
  output logic        all_finished
);
  import cpst_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Controller.
  cpst_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .func   (func),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // Datapath.
  cpst_datapath #(
    .PROCESS_SLOTS (PROCESS_SLOTS),
    .ARRIVAL_LIMIT (ARRIVAL_LIMIT)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .func             (func),
    .proc_id          (proc_id),
    .prio_level       (prio_level),
    .arrival_tick     (arrival_tick),
    .cpu_need         (cpu_need),
    .io_need          (io_need),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .done             (done),
    .load_status      (load_status),
    .tick_now         (tick_now),
    .cpu_busy         (cpu_busy),
    .run_id           (run_id),
    .run_event        (run_event),
    .was_preempted    (was_preempted),
    .io_finished      (io_finished),
    .wait_total       (wait_total),
    .turnaround_total (turnaround_total),
    .response_delay   (response_delay),
    .all_finished     (all_finished)
  );

endmodule

[sim/cpu_process_scheduler_tick_chk.sv]
// Checker for the process scheduler tick block: predicts each result and compares it.
`timescale 1ns / 100ps
module cpu_process_scheduler_tick_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  func,
  input  logic [15:0] proc_id,
  input  logic [7:0]  prio_level,
  input  logic [9:0]  arrival_tick,
  input  logic [9:0]  cpu_need,
  input  logic [9:0]  io_need,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        done,
  input  logic [1:0]  load_status,
  input  logic [15:0] tick_now,
  input  logic        cpu_busy,
  input  logic [15:0] run_id,
  input  logic [1:0]  run_event,
  input  logic        was_preempted,
  input  logic [6:0]  io_finished,
  input  logic [15:0] wait_total,
  input  logic [15:0] turnaround_total,
  input  logic [15:0] response_delay,
  input  logic        all_finished,
  output int          errors,
  output int          pending
);
  import cpst_pkg::*;

  localparam int SLOTS = int'(PROCESS_SLOTS_DEFAULT);
  localparam int ARR_MAX = int'(ARRIVAL_LIMIT_DEFAULT);

  typedef struct packed {
    logic [1:0]  load_status;
    logic [15:0] tick_now;
    logic        cpu_busy;
    logic [15:0] run_id;
    logic [1:0]  run_event;
    logic        was_preempted;
    logic [6:0]  io_finished;
    logic [15:0] wait_total;
    logic [15:0] turnaround_total;
    logic [15:0] response_delay;
    logic        all_finished;
  } sched_result_t;

  sched_result_t result_q[$];

  // Mirror of the configuration.
  logic [1:0] pol;
  logic       preempt_en;
  logic [7:0] slice_len;

  // Mirror of the process table and queues.
  logic [15:0] p_pid[SLOTS];
  logic [7:0]  p_prio[SLOTS];
  logic [9:0]  p_arr[SLOTS];
  logic [9:0]  p_cpu0[SLOTS];
  logic [9:0]  p_io0[SLOTS];
  logic [9:0]  p_cpu[SLOTS];
  logic [9:0]  p_io[SLOTS];
  logic [15:0] p_wait[SLOTS];
  logic [15:0] p_turn[SLOTS];
  logic [16:0] p_resp[SLOTS];
  logic        p_waiting[SLOTS];
  int          rdy[SLOTS];
  int          iowait[SLOTS];
  int          n_rdy, n_io, n_loaded, n_done;
  int          cur;
  logic        cur_ok;
  logic [7:0]  slice_cnt;
  logic [15:0] clock_now;

  assign pending = result_q.size();

  function automatic logic [15:0] inc_sat(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic int sort_key(int s);
    return (pol == POL_SJF) ? int'(p_cpu[s]) : int'(p_prio[s]);
  endfunction

  function automatic bit better(int a, int b);
    return sort_key(a) < sort_key(b) ||
           (sort_key(a) == sort_key(b) && p_arr[a] < p_arr[b]);
  endfunction

  task automatic rdy_push(int s);
    if (n_rdy < SLOTS) begin
      rdy[n_rdy] = s;
      n_rdy++;
    end
  endtask

  task automatic rdy_take(int idx, output int s);
    s = rdy[idx];
    for (int i = idx; i + 1 < n_rdy; i++) rdy[i] = rdy[i + 1];
    n_rdy--;
  endtask

  function automatic void rewind_run();
    for (int i = 0; i < n_loaded && i < SLOTS; i++) begin
      p_cpu[i] = p_cpu0[i];
      p_io[i] = p_io0[i];
      p_wait[i] = '0;
      p_turn[i] = '0;
      p_resp[i] = 17'h10000;
      p_waiting[i] = 1'b1;
    end
    n_rdy = 0;
    n_io = 0;
    n_done = 0;
    cur = 0;
    cur_ok = 1'b0;
    slice_cnt = '0;
    clock_now = '0;
  endfunction

  // Insert a process in pid order; returns the load status.
  function automatic logic [1:0] load_proc();
    int pos;
    bit dup;
    pos = 0;
    dup = 0;
    if (arrival_tick > ARR_MAX || cpu_need == 0 || n_loaded >= SLOTS) return LOAD_DROP;
    for (int i = 0; i < n_loaded; i++) begin
      if (p_pid[i] == proc_id) dup = 1;
      if (p_pid[i] <= proc_id) pos = i + 1;
    end
    for (int i = n_loaded; i > pos; i--) begin
      p_pid[i] = p_pid[i - 1];
      p_prio[i] = p_prio[i - 1];
      p_arr[i] = p_arr[i - 1];
      p_cpu0[i] = p_cpu0[i - 1];
      p_io0[i] = p_io0[i - 1];
    end
    p_pid[pos] = proc_id;
    p_prio[pos] = prio_level;
    p_arr[pos] = arrival_tick;
    p_cpu0[pos] = cpu_need;
    p_io0[pos] = io_need;
    n_loaded++;
    rewind_run();
    return dup ? LOAD_DUP : LOAD_OK;
  endfunction

  // One scheduler tick: arrivals, selection, aging, then one CPU tick.
  task automatic tick_proc(output sched_result_t r);
    logic [15:0] t;
    bit was_ok, swap;
    int was_slot, take, s, b, i, n_fin;
    t = clock_now;
    was_ok = cur_ok;
    was_slot = cur;
    n_fin = 0;
    r = '0;
    for (i = 0; i < n_loaded; i++)
      if (p_waiting[i] && {6'd0, p_arr[i]} == t) begin
        p_waiting[i] = 1'b0;
        rdy_push(i);
      end
    if (n_rdy > 0) begin
      take = 0;
      swap = 0;
      if (pol == POL_SJF || pol == POL_PRIO)
        for (i = 1; i < n_rdy; i++)
          if (better(rdy[i], rdy[take])) take = i;
      if (!cur_ok) begin
        swap = 1;
      end else if (pol == POL_RR) begin
        swap = slice_cnt >= slice_len;
      end else if (pol != POL_FCFS && preempt_en) begin
        b = rdy[take];
        swap = sort_key(cur) > sort_key(b) ||
               (sort_key(cur) == sort_key(b) && p_arr[cur] > p_arr[b]);
      end
      if (swap) begin
        rdy_take(take, s);
        if (cur_ok) begin
          rdy_push(cur);
          r.was_preempted = 1'b1;
        end
        cur = s;
        cur_ok = 1'b1;
      end
    end
    if (cur_ok && (!was_ok || was_slot != cur)) begin
      slice_cnt = '0;
      if (p_resp[cur][16]) p_resp[cur] = {1'b0, t - {6'd0, p_arr[cur]}};
    end
    for (i = 0; i < n_rdy; i++) begin
      p_wait[rdy[i]] = inc_sat(p_wait[rdy[i]]);
      p_turn[rdy[i]] = inc_sat(p_turn[rdy[i]]);
    end
    // IO queue: finished bursts move to the ready queue.
    i = 0;
    while (i < n_io) begin
      s = iowait[i];
      p_turn[s] = inc_sat(p_turn[s]);
      if (p_io[s] > 0) p_io[s]--;
      if (p_io[s] == 0) begin
        for (int j = i; j + 1 < n_io; j++) iowait[j] = iowait[j + 1];
        n_io--;
        rdy_push(s);
        n_fin++;
      end else begin
        i++;
      end
    end
    r.tick_now = t;
    if (cur_ok) begin
      r.cpu_busy = 1'b1;
      r.run_id = p_pid[cur];
      if (p_cpu[cur] > 0) p_cpu[cur]--;
      p_turn[cur] = inc_sat(p_turn[cur]);
      if (slice_cnt != 8'hFF) slice_cnt++;
      if (p_cpu[cur] == 0) begin
        r.run_event = EV_DONE;
        cur_ok = 1'b0;
        if (n_done < SLOTS) n_done++;
        r.wait_total = p_wait[cur];
        r.turnaround_total = p_turn[cur];
        r.response_delay = p_resp[cur][15:0];
      end else if (p_io[cur] > 0) begin
        r.run_event = EV_IO;
        cur_ok = 1'b0;
        if (n_io < SLOTS) begin
          iowait[n_io] = cur;
          n_io++;
        end
      end else begin
        r.run_event = EV_RUN;
      end
    end
    r.io_finished = n_fin[6:0];
    r.all_finished = (n_done == n_loaded);
    clock_now = inc_sat(clock_now);
  endtask

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      $display("%0t: %s got %0h expected %0h", $time, what, got, want);
      errors++;
    end
  endtask

  // Watch the channels at each rising edge.
  always @(posedge clk) begin
    sched_result_t r;
    if (rst) begin
      pol = POL_FCFS;
      preempt_en = 1'b0;
      slice_len = 8'd2;
      n_loaded = 0;
      for (int i = 0; i < SLOTS; i++) p_waiting[i] = 1'b0;
      rewind_run();
      result_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POLICY:  pol = cfg_data[1:0];
          CFG_PREEMPT: preempt_en = cfg_data[0];
          CFG_QUANTUM: slice_len = cfg_data;
          default: ;
        endcase
      end
      if (done) begin
        if (result_q.size() == 0) begin
          $display("%0t: result beat with no command outstanding", $time);
          errors++;
        end else begin
          r = result_q.pop_front();
          report("load_status", 16'(load_status), 16'(r.load_status));
          report("tick_now", tick_now, r.tick_now);
          report("cpu_busy", 16'(cpu_busy), 16'(r.cpu_busy));
          report("run_id", run_id, r.run_id);
          report("run_event", 16'(run_event), 16'(r.run_event));
          report("was_preempted", 16'(was_preempted), 16'(r.was_preempted));
          report("io_finished", 16'(io_finished), 16'(r.io_finished));
          report("wait_total", wait_total, r.wait_total);
          report("turnaround_total", turnaround_total, r.turnaround_total);
          report("response_delay", response_delay, r.response_delay);
          report("all_finished", 16'(all_finished), 16'(r.all_finished));
        end
      end
      if (start && !busy) begin
        r = '0;
        case (func)
          FUNC_LOAD:    r.load_status = load_proc();
          FUNC_TICK:    tick_proc(r);
          FUNC_RESTART: rewind_run();
          default: ;
        endcase
        result_q.push_back(r);
      end
    end
  end

endmodule

[sim/cpu_process_scheduler_tick_tb.sv]
// Testbench top for the process scheduler tick block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module cpu_process_scheduler_tick_tb;
  import cpst_pkg::*;

  localparam int ITEM_TARGET = 1650;
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func = FUNC_TICK;
  logic [15:0] proc_id = '0;
  logic [7:0]  prio_level = '0;
  logic [9:0]  arrival_tick = '0;
  logic [9:0]  cpu_need = '0;
  logic [9:0]  io_need = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        done;
  logic [1:0]  load_status;
  logic [15:0] tick_now;
  logic        cpu_busy;
  logic [15:0] run_id;
  logic [1:0]  run_event;
  logic        was_preempted;
  logic [6:0]  io_finished;
  logic [15:0] wait_total;
  logic [15:0] turnaround_total;
  logic [15:0] response_delay;
  logic        all_finished;
  int          errors;
  int          pending;
  int          items_sent = 0;
  int          idle_pct = 0;
  int          cycles = 0;

  cpu_process_scheduler_tick DUT (.*);
  cpu_process_scheduler_tick_chk u_chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("cpu_process_scheduler_tick: mismatch");
      $finish;
    end
  end

  // Issue one command beat; called and returns at a falling edge.
  task automatic send(logic [1:0] f, logic [15:0] pid, logic [7:0] pr,
                      logic [9:0] arr, logic [9:0] cpu, logic [9:0] io);
    if ($urandom_range(99) < idle_pct) repeat ($urandom_range(1, 6)) @(negedge clk);
    while (busy) @(negedge clk);
    start = 1'b1;
    func = f;
    proc_id = pid;
    prio_level = pr;
    arrival_tick = arr;
    cpu_need = cpu;
    io_need = io;
    @(negedge clk);
    start = 1'b0;
    items_sent++;
  endtask

  // Register write once every outstanding result is back.
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    while (pending != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_load();
    logic [15:0] pid;
    logic [9:0] arr, cpu, io;
    pid = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8));
    case ($urandom_range(19))
      0: arr = 10'($urandom_range(990, 1000));
      1: arr = 10'($urandom);
      default: arr = 10'($urandom_range(12));
    endcase
    cpu = ($urandom_range(19) == 0) ? 10'($urandom) : 10'($urandom_range(1, 6));
    case ($urandom_range(9))
      0: io = 10'($urandom);
      1, 2, 3: io = 10'($urandom_range(1, 4));
      default: io = '0;
    endcase
    send(FUNC_LOAD, pid, 8'($urandom), arr, cpu, io);
  endtask

  // One process set: new configuration, a restart and loads, then a run of mostly ticks.
  task automatic process_set();
    int n;
    int q;
    q = $urandom_range(4);
    write_reg(CFG_POLICY, 8'($urandom_range(3)));
    write_reg(CFG_PREEMPT, 8'($urandom_range(1)));
    write_reg(CFG_QUANTUM, q == 0 ? 8'd1 : q == 1 ? 8'd255 : 8'($urandom_range(1, 4)));
    n = ($urandom_range(7) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 8);
    send(FUNC_RESTART, '0, '0, '0, '0, '0);
    for (int i = 0; i < n; i++) random_load();
    repeat ($urandom_range(20, 70)) begin
      case ($urandom_range(99))
        0, 1: send(FUNC_RESTART, '0, '0, '0, '0, '0);
        2: send(FUNC_NOP, 16'($urandom), 8'($urandom), 10'($urandom), 10'($urandom),
                10'($urandom));
        3: random_load();
        default: send(FUNC_TICK, 16'($urandom), 8'($urandom), 10'($urandom),
                      10'($urandom), 10'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: field extremes, invalid loads, every command.
    write_reg(CFG_POLICY, {6'd0, POL_RR});
    write_reg(CFG_PREEMPT, 8'd1);
    write_reg(CFG_QUANTUM, 8'd1);
    send(FUNC_TICK, '0, '0, '0, '0, '0);
    send(FUNC_LOAD, 16'hFFFF, 8'hFF, 10'd0, 10'd1023, 10'd1023);
    send(FUNC_LOAD, 16'h0000, 8'h00, 10'd1000, 10'd1, 10'd0);
    send(FUNC_LOAD, 16'h1234, 8'h10, 10'd1001, 10'd3, 10'd0);
    send(FUNC_LOAD, 16'h1234, 8'h10, 10'd0, 10'd0, 10'd0);
    send(FUNC_LOAD, 16'h0000, 8'h01, 10'd0, 10'd2, 10'd1);
    send(FUNC_LOAD, 16'h0005, 8'h01, 10'd1, 10'd3, 10'd2);
    repeat (8) send(FUNC_TICK, '0, '0, '0, '0, '0);
    send(FUNC_NOP, 16'hFFFF, 8'hFF, 10'h3FF, 10'h3FF, 10'h3FF);
    send(FUNC_RESTART, '0, '0, '0, '0, '0);
    repeat (3) send(FUNC_TICK, '0, '0, '0, '0, '0);

    // Random part in idling phases: none, heavy, none, light.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 55 : (ph == 3) ? 13 : 0;
      while (items_sent < ITEM_TARGET * (ph + 1) / 4) process_set();
    end

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("cpu_process_scheduler_tick: match");
    end else begin
      $display("cpu_process_scheduler_tick: mismatch");
    end
    $finish;
  end

endmodule
